// ----- src/fractional_knapsack_greedy_fill_macros.svh -----
// Assertion macros for the greedy fractional knapsack fill block
`ifndef FRACTIONAL_KNAPSACK_GREEDY_FILL_MACROS_SVH
`define FRACTIONAL_KNAPSACK_GREEDY_FILL_MACROS_SVH

`ifndef SYNTH
`define FKG_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fkg check failed");
`define FKG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fkg check failed");
`else
`define FKG_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define FKG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- src/fkg_pkg.sv -----
// Package: types and constants of the greedy fractional knapsack fill block
`default_nettype none

package fkg_pkg;

    localparam int ITEM_W   = 16;
    localparam int WEIGHT_W = 24;
    localparam int SUM_W    = 42;

    localparam logic [WEIGHT_W-1:0] CAPACITY_RESET = 24'd850;
    localparam logic [SUM_W-1:0]    SUM_MAX        = {SUM_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_ACC,
        ST_OUT
    } fkg_state_t;

endpackage

`default_nettype wire

// ----- src/fractional_knapsack_greedy_fill.sv -----
// Top level: greedy fractional knapsack fill with a bit-serial divider
//
//   channel  dir  ports
//   s_       in   s_valid s_ready s_item_weight s_item_profit s_last_item
//   m_       out  m_valid m_ready m_total_profit m_filled
//   cfg_     in   cfg_valid cfg_ready cfg_capacity_limit
//
// Whole or skipped item: accepted in ST_IDLE, judged in ST_EVAL, then back to ready.
// First item that does not fit: ST_EVAL, ST_MUL, ST_DIV and ST_ACC in turn, with the
//   restoring divider in ST_DIV retiring one quotient bit per cycle.
// Last item: the result word is held until taken, then the set clears.
// Reset is synchronous, active low; capacity returns to 850.
`default_nettype none

`include "fractional_knapsack_greedy_fill_macros.svh"

module fractional_knapsack_greedy_fill
    import fkg_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire [ITEM_W-1:0]    s_item_weight,
    input  wire [ITEM_W-1:0]    s_item_profit,
    input  wire                 s_last_item,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [SUM_W-1:0]    m_total_profit,
    output logic                m_filled,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [WEIGHT_W-1:0]  cfg_capacity_limit
);

    localparam int DIV_W  = 2 * ITEM_W + FRACTION_BITS;
    localparam int CNT_W  = $clog2(DIV_W);
    localparam int WIDE_W = (DIV_W > SUM_W + 1) ? DIV_W : SUM_W + 1;

    fkg_state_t state_reg, state_next;

    logic [WEIGHT_W-1:0] capacity_reg, capacity_next;
    logic [WEIGHT_W-1:0] used_weight_reg, used_weight_next;
    logic [SUM_W-1:0]    profit_sum_reg, profit_sum_next;
    logic                full_flag_reg, full_flag_next;

    logic [ITEM_W-1:0]   weight_reg, weight_next;
    logic [ITEM_W-1:0]   profit_reg, profit_next;
    logic                last_reg, last_next;
    logic [ITEM_W-1:0]   remain_reg, remain_next;
    logic [ITEM_W-1:0]   part_rem_reg, part_rem_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [WEIGHT_W:0]   used_sum;
    logic                fits;
    logic                take_item;
    logic [WEIGHT_W-1:0] remain_full;
    logic [2*ITEM_W-1:0] mul_prod;
    logic [ITEM_W:0]     rem_shift;
    logic [ITEM_W:0]     rem_diff;
    logic                rem_ge;
    logic [WIDE_W-1:0]   quot_wide;
    logic [SUM_W:0]      add_operand;
    logic [SUM_W:0]      add_raw;
    logic [SUM_W-1:0]    add_sat;

    // shared datapath
    always_comb begin
        used_sum    = {1'b0, used_weight_reg} + (WEIGHT_W+1)'(weight_reg);
        fits        = used_sum <= {1'b0, capacity_reg};
        take_item   = !full_flag_reg && (weight_reg != '0);
        remain_full = (capacity_reg > used_weight_reg) ? capacity_reg - used_weight_reg : '0;
        mul_prod    = (2*ITEM_W)'(profit_reg) * (2*ITEM_W)'(remain_reg);
        rem_shift   = {part_rem_reg, div_reg[DIV_W-1]};
        rem_diff    = rem_shift - {1'b0, weight_reg};
        rem_ge      = rem_shift >= {1'b0, weight_reg};
        quot_wide   = WIDE_W'(div_reg);
        if (state_reg == ST_EVAL) begin
            add_operand = (SUM_W+1)'(profit_reg) << FRACTION_BITS;
        end else begin
            add_operand = quot_wide[SUM_W:0];
        end
        add_raw = {1'b0, profit_sum_reg} + add_operand;
        add_sat = add_raw[SUM_W] ? SUM_MAX : add_raw[SUM_W-1:0];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (take_item && !fits) state_next = ST_MUL;
                else if (last_reg)      state_next = ST_OUT;
                else                    state_next = ST_IDLE;
            end
            ST_MUL: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == '0) state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = last_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready        = state_reg == ST_IDLE;
        m_valid        = state_reg == ST_OUT;
        m_total_profit = profit_sum_reg;
        m_filled       = full_flag_reg;
        cfg_ready      = 1'b1;
    end

    // register next values
    always_comb begin
        capacity_next    = capacity_reg;
        used_weight_next = used_weight_reg;
        profit_sum_next  = profit_sum_reg;
        full_flag_next   = full_flag_reg;
        weight_next      = weight_reg;
        profit_next      = profit_reg;
        last_next        = last_reg;
        remain_next      = remain_reg;
        part_rem_next    = part_rem_reg;
        div_next         = div_reg;
        cnt_next         = cnt_reg;

        if (cfg_valid) capacity_next = cfg_capacity_limit;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    weight_next = s_item_weight;
                    profit_next = s_item_profit;
                    last_next   = s_last_item;
                end
            end
            ST_EVAL: begin
                // only used when the item does not fit; then below weight
                remain_next = remain_full[ITEM_W-1:0];
                if (take_item && fits) begin
                    used_weight_next = used_sum[WEIGHT_W-1:0];
                    profit_sum_next  = add_sat;
                end
            end
            ST_MUL: begin
                div_next      = DIV_W'(mul_prod) << FRACTION_BITS;
                part_rem_next = '0;
                cnt_next      = CNT_W'(DIV_W - 1);
            end
            ST_DIV: begin
                part_rem_next = rem_ge ? rem_diff[ITEM_W-1:0] : rem_shift[ITEM_W-1:0];
                div_next      = {div_reg[DIV_W-2:0], rem_ge};
                cnt_next      = cnt_reg - 1'b1;
            end
            ST_ACC: begin
                profit_sum_next = add_sat;
                full_flag_next  = 1'b1;
            end
            ST_OUT: begin
                if (m_ready) begin
                    used_weight_next = '0;
                    profit_sum_next  = '0;
                    full_flag_next   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            capacity_reg    <= CAPACITY_RESET;
            used_weight_reg <= '0;
            profit_sum_reg  <= '0;
            full_flag_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            capacity_reg    <= capacity_next;
            used_weight_reg <= used_weight_next;
            profit_sum_reg  <= profit_sum_next;
            full_flag_reg   <= full_flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        weight_reg   <= weight_next;
        profit_reg   <= profit_next;
        last_reg     <= last_next;
        remain_reg   <= remain_next;
        part_rem_reg <= part_rem_next;
        div_reg      <= div_next;
        cnt_reg      <= cnt_next;
    end

    `FKG_ASSERT_SAME(a_no_accept_while_word_waits, aclk, aresetn, m_valid, !s_ready)
    `FKG_ASSERT_NEXT(a_accept_starts_eval, aclk, aresetn,
                     s_valid && s_ready, state_reg == ST_EVAL)
    `FKG_ASSERT_SAME(a_full_only_after_divide, aclk, aresetn,
                     $rose(full_flag_reg), $past(state_reg) == ST_ACC)
    `FKG_ASSERT_NEXT(a_divide_ends_in_acc, aclk, aresetn,
                     state_reg == ST_DIV && cnt_reg == '0, state_reg == ST_ACC)

endmodule

`default_nettype wire
